### rtl/sscm_pkg.sv
// shared widths, register indexes, reset values and sideband type for the setting step block
package sscm_pkg;

  localparam int VALUE_BITS  = 8;
  localparam int NUM_POINTS  = 5;
  localparam int CURVE_BITS  = NUM_POINTS * VALUE_BITS;
  localparam int PROD_BITS   = 2 * VALUE_BITS;
  localparam int INDEX_BITS  = 3;
  localparam int DIV_STAGES  = PROD_BITS / 2;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  localparam logic [INDEX_BITS-1:0] REG_MIN_VALUE   = INDEX_BITS'(0);
  localparam logic [INDEX_BITS-1:0] REG_MAX_VALUE   = INDEX_BITS'(1);
  localparam logic [INDEX_BITS-1:0] REG_STEP_SIZE   = INDEX_BITS'(2);
  localparam logic [INDEX_BITS-1:0] REG_BREAKPOINTS = INDEX_BITS'(3);
  localparam logic [INDEX_BITS-1:0] REG_LEVELS      = INDEX_BITS'(4);

  localparam logic [VALUE_BITS-1:0] MIN_RESET  = VALUE_BITS'(0);
  localparam logic [VALUE_BITS-1:0] MAX_RESET  = VALUE_BITS'(100);
  localparam logic [VALUE_BITS-1:0] STEP_RESET = VALUE_BITS'(1);
  localparam logic [CURVE_BITS-1:0] CURVE_RESET = {
    VALUE_BITS'(100), VALUE_BITS'(75), VALUE_BITS'(50), VALUE_BITS'(25), VALUE_BITS'(0)
  };

  // fields that ride alongside the divider
  typedef struct packed {
    logic [VALUE_BITS-1:0] new_value;
    logic                  changed;
    logic [VALUE_BITS-1:0] base;
  } side_t;

endpackage

### rtl/setting_step_with_curve_map.sv
// setting step with saturation and five point piecewise-linear curve map
//
//  channel  signals                          direction  transfer when
//  req      go_up, current_value             in         req_valid && req_ready
//  rsp      new_value, changed, mapped_value out        rsp_valid && rsp_ready
//  cfg      cfg_index, cfg_wdata             in         cfg_wen
//
// one item enters per cycle while the output is not stalled; the stages in order:
// step, segment select, multiply, VALUE_BITS divider stages of two quotient bits, sum
// the divider pipeline sets the depth; each stage holds a valid bit
// rst clears valid bits and loads register reset values
// a stalled output holds; each stage moves whenever the next one is empty or moving
module setting_step_with_curve_map (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [sscm_pkg::INDEX_BITS-1:0]  cfg_index,
  input  logic [sscm_pkg::CURVE_BITS-1:0]  cfg_wdata,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic                             go_up,
  input  logic [sscm_pkg::VALUE_BITS-1:0]  current_value,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output logic [sscm_pkg::VALUE_BITS-1:0]  new_value,
  output logic                             changed,
  output logic [sscm_pkg::VALUE_BITS-1:0]  mapped_value
);
  import sscm_pkg::*;

  localparam int VB = VALUE_BITS;

  logic [VB-1:0]         min_value;
  logic [VB-1:0]         max_value;
  logic [VB-1:0]         step_size;
  logic [CURVE_BITS-1:0] curve_breakpoints;
  logic [CURVE_BITS-1:0] curve_levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value         <= MIN_RESET;
      max_value         <= MAX_RESET;
      step_size         <= STEP_RESET;
      curve_breakpoints <= CURVE_RESET;
      curve_levels      <= CURVE_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MIN_VALUE:   min_value         <= cfg_wdata[VB-1:0];
        REG_MAX_VALUE:   max_value         <= cfg_wdata[VB-1:0];
        REG_STEP_SIZE:   step_size         <= cfg_wdata[VB-1:0];
        REG_BREAKPOINTS: curve_breakpoints <= cfg_wdata;
        REG_LEVELS:      curve_levels      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- stage 0: saturating step
  logic          s0_valid, s0_ready;
  logic [VB-1:0] s0_value;
  logic          s0_changed;
  logic [VB-1:0] step_next;

  always_comb begin
    logic [VB:0] sum;
    logic [VB:0] diff;
    step_next = current_value;
    sum  = {1'b0, current_value} + {1'b0, step_size};
    diff = {1'b0, current_value} - {1'b0, step_size};
    if (go_up) begin
      if (current_value < max_value) begin
        step_next = (sum > {1'b0, max_value}) ? max_value : sum[VB-1:0];
      end
    end else begin
      if (current_value > min_value) begin
        // borrow out means the step went below zero
        step_next = (diff[VB] || diff[VB-1:0] < min_value) ? min_value : diff[VB-1:0];
      end
    end
  end

  // ---------------- stage 1: segment select, span and distance
  logic          s1_valid, s1_ready;
  logic [VB-1:0] s1_span, s1_dist, s1_den;
  side_t         s1_side;

  logic [VB-1:0] pt_x [NUM_POINTS];
  logic [VB-1:0] pt_l [NUM_POINTS];
  for (genvar i = 0; i < NUM_POINTS; i++) begin : g_pts
    assign pt_x[i] = curve_breakpoints[i*VB +: VB];
    assign pt_l[i] = curve_levels[i*VB +: VB];
  end

  logic [VB-1:0] seg_span, seg_dist, seg_den, seg_base;

  always_comb begin
    logic [VB-1:0] v, xs, xe, ls, le;
    logic [VB:0]   w, d;
    logic          rising;
    v = (s0_value < pt_x[0]) ? pt_x[0] : s0_value;
    if (v < pt_x[1]) begin
      xs = pt_x[0]; xe = pt_x[1]; ls = pt_l[0]; le = pt_l[1];
    end else if (v < pt_x[2]) begin
      xs = pt_x[1]; xe = pt_x[2]; ls = pt_l[1]; le = pt_l[2];
    end else if (v < pt_x[3]) begin
      xs = pt_x[2]; xe = pt_x[3]; ls = pt_l[2]; le = pt_l[3];
    end else begin
      xs = pt_x[3]; xe = pt_x[4]; ls = pt_l[3]; le = pt_l[4];
    end
    w = {1'b0, xe} - {1'b0, xs};
    rising = le > ls;
    d = rising ? ({1'b0, v} - {1'b0, xs}) : ({1'b0, xe} - {1'b0, v});
    seg_span = rising ? (le - ls) : (ls - le);
    seg_dist = d[VB] ? '0 : d[VB-1:0];
    seg_den  = w[VB-1:0];
    seg_base = rising ? ls : le;
    // empty or reversed segment: result is the start level
    if (w[VB] || w == '0) begin
      seg_dist = '0;
      seg_den  = VB'(1);
      seg_base = ls;
    end
  end

  // ---------------- stage 2: product
  logic                 s2_valid, s2_ready;
  logic [PROD_BITS-1:0] s2_prod;
  logic [VB-1:0]        s2_den;
  side_t                s2_side;

  // ---------------- divider and output stage
  logic                 div_in_ready, div_valid, out_ready;
  logic [PROD_BITS-1:0] div_quo;
  side_t                div_side;

  assign out_ready = !rsp_valid || rsp_ready;
  assign s2_ready  = !s2_valid || div_in_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign s0_ready  = !s0_valid || s1_ready;
  assign req_ready = s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s0_ready) s0_valid <= req_valid;
      if (s1_ready) s1_valid <= s0_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
    if (s0_ready) begin
      s0_value   <= step_next;
      s0_changed <= step_next != current_value;
    end
    if (s1_ready) begin
      s1_span           <= seg_span;
      s1_dist           <= seg_dist;
      s1_den            <= seg_den;
      s1_side.new_value <= s0_value;
      s1_side.changed   <= s0_changed;
      s1_side.base      <= seg_base;
    end
    if (s2_ready) begin
      s2_prod <= s1_span * s1_dist;
      s2_den  <= s1_den;
      s2_side <= s1_side;
    end
  end

  sscm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (div_in_ready),
    .dividend  (s2_prod),
    .divisor   (s2_den),
    .in_side   (s2_side),
    .out_valid (div_valid),
    .out_ready (out_ready),
    .quotient  (div_quo),
    .out_side  (div_side)
  );

  logic [PROD_BITS:0] level_sum;
  assign level_sum = (PROD_BITS+1)'(div_side.base) + (PROD_BITS+1)'(div_quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_ready) begin
      rsp_valid <= div_valid;
    end
    if (out_ready) begin
      new_value    <= div_side.new_value;
      changed      <= div_side.changed;
      mapped_value <= (level_sum > (PROD_BITS+1)'(VALUE_MAX)) ? VALUE_MAX
                                                              : level_sum[VB-1:0];
    end
  end

endmodule

### rtl/sscm_div.sv
// pipelined restoring divider, two quotient bits per stage, with sideband
module sscm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sscm_pkg::PROD_BITS-1:0]  dividend,
  input  logic [sscm_pkg::VALUE_BITS-1:0] divisor,
  input  sscm_pkg::side_t              in_side,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sscm_pkg::PROD_BITS-1:0]  quotient,
  output sscm_pkg::side_t              out_side
);
  import sscm_pkg::*;

  logic                  vld [DIV_STAGES];
  logic                  rdy [DIV_STAGES+1];
  logic [VALUE_BITS-1:0] rem [DIV_STAGES];
  logic [PROD_BITS-1:0]  num [DIV_STAGES];
  logic [PROD_BITS-1:0]  quo [DIV_STAGES];
  logic [VALUE_BITS-1:0] den [DIV_STAGES];
  side_t                 sd  [DIV_STAGES];

  assign rdy[DIV_STAGES] = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = vld[DIV_STAGES-1];
  assign quotient  = quo[DIV_STAGES-1];
  assign out_side  = sd[DIV_STAGES-1];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic                  src_vld;
    logic [VALUE_BITS-1:0] src_rem;
    logic [PROD_BITS-1:0]  src_num;
    logic [PROD_BITS-1:0]  src_quo;
    logic [VALUE_BITS-1:0] src_den;
    side_t                 src_sd;
    logic [VALUE_BITS-1:0] rem_next;
    logic [PROD_BITS-1:0]  num_next;
    logic [PROD_BITS-1:0]  quo_next;

    if (k == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rem = '0;
      assign src_num = dividend;
      assign src_quo = '0;
      assign src_den = divisor;
      assign src_sd  = in_side;
    end else begin : g_rest
      assign src_vld = vld[k-1];
      assign src_rem = rem[k-1];
      assign src_num = num[k-1];
      assign src_quo = quo[k-1];
      assign src_den = den[k-1];
      assign src_sd  = sd[k-1];
    end

    always_comb begin
      logic [VALUE_BITS:0]   trial;
      logic [VALUE_BITS-1:0] r;
      logic [PROD_BITS-1:0]  n;
      logic [PROD_BITS-1:0]  q;
      r = src_rem;
      n = src_num;
      q = src_quo;
      for (int j = 0; j < 2; j++) begin
        trial = {r, n[PROD_BITS-1]};
        n = {n[PROD_BITS-2:0], 1'b0};
        if (trial >= {1'b0, src_den}) begin
          trial = trial - {1'b0, src_den};
          q = {q[PROD_BITS-2:0], 1'b1};
        end else begin
          q = {q[PROD_BITS-2:0], 1'b0};
        end
        r = trial[VALUE_BITS-1:0];
      end
      rem_next = r;
      num_next = n;
      quo_next = q;
    end

    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= src_vld;
      end
      if (rdy[k]) begin
        rem[k] <= rem_next;
        num[k] <= num_next;
        quo[k] <= quo_next;
        den[k] <= src_den;
        sd[k]  <= src_sd;
      end
    end
  end

endmodule

### rtl/sscm_chk.sv
// port-level checks for the setting step block, bound to the top level
module sscm_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [sscm_pkg::VALUE_BITS-1:0] new_value,
  input logic                            changed,
  input logic [sscm_pkg::VALUE_BITS-1:0] mapped_value
);
  import sscm_pkg::*;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // a free output slot means every stage can move
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid || rsp_ready) |-> req_ready)
    else $error("input stalled while output slot free");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(new_value) && $stable(changed)
      && $stable(mapped_value))
    else $error("stalled result changed");

  // no result can appear in the cycle after reset ends without earlier input
  a_no_early: assert property (@(posedge clk)
    $fell(rst) |-> !rsp_valid)
    else $error("result present as reset ends");

endmodule

bind setting_step_with_curve_map sscm_chk u_sscm_chk (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req_ready),
  .rsp_valid    (rsp_valid),
  .rsp_ready    (rsp_ready),
  .new_value    (new_value),
  .changed      (changed),
  .mapped_value (mapped_value)
);

### dv/setting_step_with_curve_map_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the setting step and curve map block
module setting_step_with_curve_map_tb;
  import sscm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = VALUE_BITS + 8;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [VALUE_BITS-1:0] new_value;
    logic                  changed;
    logic [VALUE_BITS-1:0] mapped_value;
  } step_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [INDEX_BITS-1:0] cfg_index;
  logic [CURVE_BITS-1:0] cfg_wdata;
  logic                  req_valid;
  logic                  req_ready;
  logic                  go_up;
  logic [VALUE_BITS-1:0] current_value;
  logic                  rsp_valid;
  logic                  rsp_ready;
  logic [VALUE_BITS-1:0] new_value;
  logic                  changed;
  logic [VALUE_BITS-1:0] mapped_value;

  // register copies used for prediction
  logic [VALUE_BITS-1:0] set_min;
  logic [VALUE_BITS-1:0] set_max;
  logic [VALUE_BITS-1:0] set_step;
  logic [CURVE_BITS-1:0] set_points;
  logic [CURVE_BITS-1:0] set_levels;

  step_result_t pending_results[$];
  bit           no_idle;
  int           rx_hold_left;
  int           cycle_count;
  int           mismatches;
  int           n_sent;
  int           n_checked;
  int           n_settings;

  setting_step_with_curve_map u_dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic step_result_t step_and_map(input logic up,
                                                input logic [VALUE_BITS-1:0] cur);
    int xp[NUM_POINTS];
    int lv[NUM_POINTS];
    int lo, hi, stp, cur_i, nv, v, s, xs, xe, ls, le, w, offs, r;
    step_result_t res;
    lo    = int'(set_min);
    hi    = int'(set_max);
    stp   = int'(set_step);
    cur_i = int'(cur);
    nv    = cur_i;
    if (up) begin
      if (cur_i < hi) begin
        nv = cur_i + stp;
        if (nv > hi) nv = hi;
      end
    end else if (cur_i > lo) begin
      nv = cur_i - stp;
      if (nv < lo) nv = lo;
    end
    for (int i = 0; i < NUM_POINTS; i++) begin
      xp[i] = int'(set_points[i*VALUE_BITS +: VALUE_BITS]);
      lv[i] = int'(set_levels[i*VALUE_BITS +: VALUE_BITS]);
    end
    v = (nv < xp[0]) ? xp[0] : nv;
    if (v < xp[1]) s = 0;
    else if (v < xp[2]) s = 1;
    else if (v < xp[3]) s = 2;
    else s = 3;
    xs = xp[s];
    xe = xp[s+1];
    ls = lv[s];
    le = lv[s+1];
    w  = xe - xs;
    if (w <= 0) begin
      r = ls;
    end else if (le > ls) begin
      offs = v - xs;
      if (offs < 0) offs = 0;
      r = ls + ((le - ls) * offs) / w;
    end else begin
      // falling segment measures from the far end
      offs = xe - v;
      if (offs < 0) offs = 0;
      r = le + ((ls - le) * offs) / w;
    end
    if (r > int'(VALUE_MAX)) r = int'(VALUE_MAX);
    res.new_value    = nv[VALUE_BITS-1:0];
    res.changed      = (nv != cur_i);
    res.mapped_value = r[VALUE_BITS-1:0];
    return res;
  endfunction

  // called and returns at a falling edge; valid stays up between back-to-back items
  task automatic send_item(input logic up, input logic [VALUE_BITS-1:0] cur);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 23) gap++;
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid     <= 1'b1;
    go_up         <= up;
    current_value <= cur;
    do @(posedge clk); while (!req_ready);
    pending_results.push_back(step_and_map(up, cur));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_settings(input logic [VALUE_BITS-1:0] lo, input logic [VALUE_BITS-1:0] hi,
                               input logic [VALUE_BITS-1:0] stp,
                               input logic [CURVE_BITS-1:0] pts,
                               input logic [CURVE_BITS-1:0] lvl);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_MIN_VALUE;
    cfg_wdata <= CURVE_BITS'(lo);
    @(negedge clk);
    cfg_index <= REG_MAX_VALUE;
    cfg_wdata <= CURVE_BITS'(hi);
    @(negedge clk);
    cfg_index <= REG_STEP_SIZE;
    cfg_wdata <= CURVE_BITS'(stp);
    @(negedge clk);
    cfg_index <= REG_BREAKPOINTS;
    cfg_wdata <= pts;
    @(negedge clk);
    cfg_index <= REG_LEVELS;
    cfg_wdata <= lvl;
    @(negedge clk);
    cfg_wen    <= 1'b0;
    set_min    = lo;
    set_max    = hi;
    set_step   = stp;
    set_points = pts;
    set_levels = lvl;
    n_settings++;
  endtask

  task automatic test_reset_defaults();
    send_item(1'b1, 8'd0);
    send_item(1'b0, 8'd0);
    send_item(1'b1, 8'd100);
    send_item(1'b1, 8'd255);
    send_item(1'b0, 8'd255);
    send_item(1'b1, 8'd99);
    wait_for_results();
  endtask

  task automatic test_step_limits();
    // last segment has zero width; middle segments rise, fall and stay flat
    load_settings(8'd20, 8'd200, 8'd30, {8'd160, 8'd160, 8'd120, 8'd80, 8'd40},
                  {8'd10, 8'd60, 8'd60, 8'd255, 8'd0});
    send_item(1'b0, 8'd25);
    send_item(1'b0, 8'd20);
    send_item(1'b0, 8'd10);
    send_item(1'b1, 8'd190);
    send_item(1'b1, 8'd200);
    send_item(1'b1, 8'd230);
    send_item(1'b1, 8'd50);
    send_item(1'b1, 8'd90);
    wait_for_results();
  endtask

  task automatic test_curve_guards();
    // unordered breakpoints, full-range step
    load_settings(8'd0, 8'd255, 8'd255, {8'd100, 8'd200, 8'd20, 8'd50, 8'd10},
                  {8'd255, 8'd0, 8'd255, 8'd255, 8'd100});
    send_item(1'b1, 8'd0);
    send_item(1'b0, 8'd255);
    send_item(1'b0, 8'd0);
    send_item(1'b1, 8'd255);
    wait_for_results();
    // zero step and steep rising extrapolation past the last breakpoint
    load_settings(8'd0, 8'd255, 8'd0, {8'd40, 8'd30, 8'd20, 8'd10, 8'd0},
                  {8'd250, 8'd150, 8'd100, 8'd50, 8'd0});
    send_item(1'b1, 8'd100);
    send_item(1'b0, 8'd35);
    send_item(1'b1, 8'd5);
    wait_for_results();
    // falling last segment clamps above its end
    load_settings(8'd0, 8'd255, 8'd1, {8'd224, 8'd192, 8'd128, 8'd64, 8'd0},
                  {8'd0, 8'd255, 8'd128, 8'd0, 8'd255});
    send_item(1'b1, 8'd250);
    send_item(1'b0, 8'd200);
    send_item(1'b1, 8'd0);
    wait_for_results();
  endtask

  task automatic test_backpressure();
    rx_hold_left = HOLD_CYCLES;
    no_idle      = 1'b1;
    for (int i = 0; i < 80; i++) begin
      send_item(1'($urandom_range(0, 1)), VALUE_BITS'($urandom_range(0, 255)));
    end
    no_idle = 1'b0;
    wait_for_results();
  endtask

  task automatic test_random_settings();
    logic [VALUE_BITS-1:0] lo, hi, stp, t;
    logic [VALUE_BITS-1:0] b [NUM_POINTS];
    logic [CURVE_BITS-1:0] pts, lvl;
    int n_items, c;
    for (int p = 0; p < 24; p++) begin
      case ($urandom_range(0, 5))
        0:       lo = '0;
        1:       lo = VALUE_MAX;
        default: lo = VALUE_BITS'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       hi = '0;
        1:       hi = VALUE_MAX;
        default: hi = VALUE_BITS'($urandom_range(0, 255));
      endcase
      // mostly keep the limits ordered
      if (hi < lo && $urandom_range(0, 4) != 0) begin
        t  = hi;
        hi = lo;
        lo = t;
      end
      case ($urandom_range(0, 7))
        0:       stp = VALUE_MAX;
        1:       stp = '0;
        2:       stp = VALUE_BITS'(1);
        default: stp = VALUE_BITS'($urandom_range(1, 40));
      endcase
      if (p == 0) begin
        lo  = '0;
        hi  = VALUE_MAX;
        stp = VALUE_BITS'(1);
      end else if (p == 1) begin
        lo  = '0;
        hi  = VALUE_MAX;
        stp = VALUE_MAX;
      end else if (p == 2) begin
        lo  = VALUE_MAX;
        hi  = '0;
        stp = VALUE_MAX;
      end
      for (int i = 0; i < NUM_POINTS; i++) b[i] = VALUE_BITS'($urandom_range(0, 255));
      for (int i = 0; i < NUM_POINTS - 1; i++) begin
        for (int j = 0; j < NUM_POINTS - 1 - i; j++) begin
          if (b[j] > b[j+1]) begin
            t      = b[j];
            b[j]   = b[j+1];
            b[j+1] = t;
          end
        end
      end
      case ($urandom_range(0, 5))
        0:       pts = CURVE_BITS'({$urandom, $urandom});
        1:       pts = CURVE_RESET;
        2:       pts = {b[3], b[3], b[2], b[1], b[0]};
        default: pts = {b[4], b[3], b[2], b[1], b[0]};
      endcase
      for (int i = 0; i < NUM_POINTS; i++) begin
        if ($urandom_range(0, 4) == 0) b[i] = $urandom_range(0, 1) ? VALUE_MAX : '0;
        else b[i] = VALUE_BITS'($urandom_range(0, 255));
      end
      lvl = (p == 0) ? {NUM_POINTS{VALUE_MAX}} : {b[4], b[3], b[2], b[1], b[0]};
      load_settings(lo, hi, stp, pts, lvl);

      // one long phase with neither side idling
      n_items = (p == 6) ? 200 : 60;
      no_idle = (p == 6);
      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(0, 4))
          0:       c = int'(hi) + $urandom_range(0, 6) - 3;
          1:       c = int'(lo) + $urandom_range(0, 6) - 3;
          default: c = $urandom_range(0, 255);
        endcase
        if (c < 0) c = 0;
        if (c > int'(VALUE_MAX)) c = int'(VALUE_MAX);
        send_item(1'($urandom_range(0, 1)), VALUE_BITS'(c));
      end
      no_idle = 1'b0;
      wait_for_results();
    end
  endtask

  // response side: random stalls, plus a long hold when requested
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rsp_ready <= 1'b0;
      rx_hold_left--;
    end else if (no_idle) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= 23);
    end
  end

  always @(posedge clk) begin : check_results
    step_result_t want;
    cycle_count++;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_results.size() == 0) begin
        $error("response transfer with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (new_value !== want.new_value) begin
          $error("new_value: expected %0d, got %0d", want.new_value, new_value);
          mismatches++;
        end
        if (changed !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, changed);
          mismatches++;
        end
        if (mapped_value !== want.mapped_value) begin
          $error("mapped_value: expected %0d, got %0d", want.mapped_value, mapped_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d responses outstanding",
             cycle_count, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_index     = REG_MIN_VALUE;
    cfg_wdata     = '0;
    req_valid     = 1'b0;
    go_up         = 1'b0;
    current_value = '0;
    rsp_ready     = 1'b0;
    no_idle       = 1'b0;
    rx_hold_left  = 0;
    cycle_count   = 0;
    mismatches    = 0;
    n_sent        = 0;
    n_checked     = 0;
    n_settings    = 1;
    set_min       = MIN_RESET;
    set_max       = MAX_RESET;
    set_step      = STEP_RESET;
    set_points    = CURVE_RESET;
    set_levels    = CURVE_RESET;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_step_limits();
    test_curve_guards();
    test_backpressure();
    test_random_settings();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d requests sent, %0d responses checked over %0d register settings",
             n_sent, n_checked, n_settings);
    $display("covered step limits, zero step, curve clamps, extrapolation, flat and unordered"
             , " segments, and a %0d-cycle output hold", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
